### src/assert_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, masked while reset is held.
`define QPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define QPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/qpe_pkg.sv
// Shared types, constants and helper functions of the quoted-printable encoder.
package qpe_pkg;

  // Character codes
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Literal ranges
  localparam logic [7:0] LIT_LO_A = 8'd33;
  localparam logic [7:0] LIT_HI_A = 8'd60;
  localparam logic [7:0] LIT_LO_B = 8'd62;
  localparam logic [7:0] LIT_HI_B = 8'd126;

  // Configuration
  localparam logic [7:0] RESET_THRESHOLD = 8'd76;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic {
    CFG_EBCDIC_SAFE    = 1'b0,
    CFG_LINE_THRESHOLD = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  // Held whitespace codes
  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_TAB   = 2'd1;
  localparam logic [1:0] HELD_SPACE = 2'd2;

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Output slots of one item, emitted in ascending order
  localparam int unsigned NUM_SLOTS = 10;
  localparam int unsigned SLOT_W    = 4;
  localparam logic [SLOT_W-1:0] SLOT_B1_EQ = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1_CR = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_B1_LF = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_WS    = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_B2_EQ = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_B2_CR = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_B2_LF = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_BODY0 = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_HEX_H = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_HEX_L = 4'd9;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // Work descriptor handed from front to back
  typedef struct packed {
    logic       brk1;    // soft break before the held whitespace
    logic       ws_vld;  // held whitespace goes out
    logic       ws_tab;  // it is a tab, else a space
    logic       brk2;    // soft break before the body
    logic       lit;     // body is the byte itself
    logic       hex;     // body is =XY
    logic [7:0] byte_value;
  } qpe_desc_t;

  // Upper-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = 8'h30 + {4'd0, nib};
    else             r = 8'h37 + {4'd0, nib};
    return r;
  endfunction

  // Punctuation that does not survive EBCDIC gateways
  function automatic logic ebcdic_unsafe(input logic [7:0] c);
    logic r;
    case (c)
      8'd33, 8'd34, 8'd35, 8'd36, 8'd64, 8'd91, 8'd92, 8'd93, 8'd94, 8'd96,
      8'd123, 8'd124, 8'd125, 8'd126: r = 1'b1;
      default:                        r = 1'b0;
    endcase
    return r;
  endfunction

  // Which output slots a descriptor fills
  function automatic slot_mask_t desc_mask(input qpe_desc_t d);
    slot_mask_t m;
    m             = '0;
    m[SLOT_B1_EQ] = d.brk1;
    m[SLOT_B1_CR] = d.brk1;
    m[SLOT_B1_LF] = d.brk1;
    m[SLOT_WS]    = d.ws_vld;
    m[SLOT_B2_EQ] = d.brk2;
    m[SLOT_B2_CR] = d.brk2;
    m[SLOT_B2_LF] = d.brk2;
    m[SLOT_BODY0] = d.lit | d.hex;
    m[SLOT_HEX_H] = d.hex;
    m[SLOT_HEX_L] = d.hex;
    return m;
  endfunction

endpackage

### src/qpe_in_if.sv
// Input channel: one byte or an end-of-input command per beat.
interface qpe_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] byte_value;

  modport source (output valid, output cmd, output byte_value, input ready);
  modport sink   (input valid, input cmd, input byte_value, output ready);
endinterface

### src/qpe_out_if.sv
// Output channel: one encoded character per beat.
interface qpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

### src/qpe_front.sv
// Front end: classifies input beats, tracks line length and held whitespace.
module qpe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ebcdic_safe,
  input  logic [7:0]          line_threshold,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                q_push,
  output qpe_pkg::qpe_desc_t  q_desc
);
  import qpe_pkg::*;

  logic [7:0] line_count_r, line_count_nxt;
  logic [1:0] held_r, held_nxt;

  logic       accept;
  logic       is_tab, is_space, is_lit;
  logic [8:0] sum1, sum2;
  logic [7:0] cnt1, n2;
  logic       b1, b2;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // Classify the byte
  always_comb begin
    is_tab   = (in_byte == CHAR_TAB);
    is_space = (in_byte == CHAR_SPACE);
    is_lit   = (((in_byte >= LIT_LO_A) && (in_byte <= LIT_HI_A)) ||
                ((in_byte >= LIT_LO_B) && (in_byte <= LIT_HI_B))) &&
               !(ebcdic_safe && ebcdic_unsafe(in_byte));
  end

  // Line accounting: flush of held whitespace, then the body
  always_comb begin
    sum1 = {1'b0, line_count_r} + 9'd1;
    b1   = (held_r != HELD_NONE) && (sum1 >= {1'b0, line_threshold});
    if (held_r == HELD_NONE) cnt1 = line_count_r;
    else if (b1)             cnt1 = 8'd1;
    else                     cnt1 = sum1[7:0];

    n2   = is_lit ? 8'd1 : 8'd3;
    sum2 = {1'b0, cnt1} + {1'b0, n2};

    q_desc            = '0;
    q_desc.brk1       = b1;
    q_desc.ws_vld     = (held_r != HELD_NONE);
    q_desc.ws_tab     = (held_r == HELD_TAB);
    q_desc.byte_value = in_byte;

    line_count_nxt = line_count_r;
    held_nxt       = held_r;
    b2             = 1'b0;
    q_push         = 1'b0;

    if (accept) begin
      if (in_cmd == CMD_END) begin
        b2             = (cnt1 != 8'd0);
        line_count_nxt = 8'd0;
        held_nxt       = HELD_NONE;
        q_push         = q_desc.ws_vld || b2;
      end else if (is_tab || is_space) begin
        line_count_nxt = cnt1;
        held_nxt       = is_tab ? HELD_TAB : HELD_SPACE;
        q_push         = q_desc.ws_vld;
      end else begin
        b2             = (sum2 >= {1'b0, line_threshold});
        line_count_nxt = b2 ? n2 : sum2[7:0];
        held_nxt       = HELD_NONE;
        q_desc.lit     = is_lit;
        q_desc.hex     = !is_lit;
        q_push         = 1'b1;
      end
    end
    q_desc.brk2 = b2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
      held_r       <= HELD_NONE;
    end else begin
      line_count_r <= line_count_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule

### src/qpe_queue.sv
// Small descriptor queue between the front end and the emitter.
`include "assert_macros.svh"
module qpe_queue #(
  parameter int unsigned DEPTH = qpe_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qpe_pkg::qpe_desc_t  push_desc,
  input  logic                pop,
  output qpe_pkg::qpe_desc_t  head_desc,
  output logic                empty,
  output logic                full
);
  import qpe_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qpe_desc_t     mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty     = (count_r == '0);
  assign full      = (count_r == FULL_CNT);
  assign head_desc = mem_r[rd_ptr_r];

  // Pointer and fill-level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_desc;
  end

  `QPE_ASSERT(a_no_overflow, !(push && full), "queue push while full")
  `QPE_ASSERT(a_no_underflow, !(pop && empty), "queue pop while empty")
  `QPE_ASSERT(a_count_bound, count_r <= FULL_CNT, "queue fill level out of range")

endmodule

### src/qpe_back.sv
// Emitter: walks the output slots of each descriptor, one character per beat.
`include "assert_macros.svh"
module qpe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  qpe_pkg::qpe_desc_t  head_desc,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                out_last
);
  import qpe_pkg::*;

  slot_mask_t  pm_r, pm_nxt;
  qpe_desc_t   desc_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  qpe_desc_t         cur_desc;
  slot_mask_t        cur_mask, sel, rem;
  logic [SLOT_W-1:0] slot;
  logic              out_free, use_head, emit;
  logic [7:0]        ch;

  assign out_free = !out_valid_r || out_ready;
  assign use_head = (pm_r == '0) && !q_empty;
  assign cur_desc = use_head ? head_desc : desc_r;
  assign cur_mask = use_head ? desc_mask(head_desc) : pm_r;
  assign emit     = out_free && (cur_mask != '0);
  assign q_pop    = out_free && use_head;

  // Lowest pending slot
  always_comb begin
    sel  = cur_mask & (~cur_mask + slot_mask_t'(1));
    rem  = cur_mask & ~sel;
    slot = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) slot = SLOT_W'(i);
    end
  end

  // Character for the selected slot
  always_comb begin
    unique case (slot) inside
      SLOT_B1_EQ, SLOT_B2_EQ: ch = CHAR_EQ;
      SLOT_B1_CR, SLOT_B2_CR: ch = CHAR_CR;
      SLOT_B1_LF, SLOT_B2_LF: ch = CHAR_LF;
      SLOT_WS:                ch = cur_desc.ws_tab ? CHAR_TAB : CHAR_SPACE;
      SLOT_BODY0:             ch = cur_desc.lit ? cur_desc.byte_value : CHAR_EQ;
      SLOT_HEX_H:             ch = hex_char(cur_desc.byte_value[7:4]);
      SLOT_HEX_L:             ch = hex_char(cur_desc.byte_value[3:0]);
      default:                ch = CHAR_EQ;
    endcase
  end

  // Output register and remaining-slot tracking
  always_comb begin
    pm_nxt        = pm_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = emit;
      if (emit) begin
        pm_nxt       = rem;
        out_char_nxt = ch;
        out_last_nxt = (rem == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pm_r        <= pm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (q_pop) desc_r <= head_desc;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `QPE_ASSERT(a_pending_shown, (pm_r != '0) |-> out_valid_r,
              "slots pending without a character on the output")
  `QPE_ASSERT(a_last_drains, (out_valid_r && out_last_r) |-> (pm_r == '0),
              "last beat flagged while slots remain")
  `QPE_ASSERT(a_pop_when_done, q_pop |-> (pm_r == '0),
              "new descriptor taken before the current one finished")

endmodule

### src/quoted_printable_encoder.sv
// Quoted-printable encoder top: byte or end-command beats in, encoded characters out.
// The first character of an item passes through the descriptor queue and then the output
// register. Throughput: one character per cycle while the output is not stalled, so an item
// gives 0 to 10 characters (literal 1, hex 3, each soft break 3, held whitespace 1).
// One input beat per cycle is taken while the descriptor queue has room.
// Reset (rst_n low, synchronous): state and queue clear, ebcdic_safe 0, line_threshold 76.
module quoted_printable_encoder #(
  parameter int unsigned QUEUE_DEPTH = qpe_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  qpe_in_if.sink                        in_ch,
  qpe_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [qpe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import qpe_pkg::*;

  logic       ebcdic_safe_r;
  logic [7:0] line_threshold_r;

  logic       q_push, q_pop, q_full, q_empty;
  qpe_desc_t  push_desc, head_desc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ebcdic_safe_r    <= 1'b0;
      line_threshold_r <= RESET_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_EBCDIC_SAFE:    ebcdic_safe_r    <= cfg_wdata[0];
        CFG_LINE_THRESHOLD: line_threshold_r <= cfg_wdata[7:0];
        default:            ;
      endcase
    end
  end

  qpe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .ebcdic_safe    (ebcdic_safe_r),
    .line_threshold (line_threshold_r),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_cmd         (in_ch.cmd),
    .in_byte        (in_ch.byte_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_desc         (push_desc)
  );

  qpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .empty     (q_empty),
    .full      (q_full)
  );

  qpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_desc (head_desc),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .out_last  (out_ch.last)
  );

endmodule
